[hdl/tct_pkg.sv]
`timescale 1ns / 1ps
package tct_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IvalW  = 21;
  localparam int unsigned InstW  = 6;

  // One slot word in the data memory: send time, then trade price, trade quantity, open, min and max price.
  localparam int unsigned DataW  = TimeW + 5 * PriceW;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_TRD,
    ST_TQ,
    ST_TEV,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0]  sent_time;
    logic [PriceW-1:0] trade_price;
    logic [PriceW-1:0] trade_qty;
    logic [PriceW-1:0] open_price;
    logic [PriceW-1:0] min_price;
    logic [PriceW-1:0] max_price;
  } slot_word_t;

endpackage

[hdl/tct_if.sv]
`timescale 1ns / 1ps
interface tct_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         instrument;
  logic signed [31:0] trade_price;
  logic signed [31:0] trade_qty;
  logic signed [31:0] open_price;
  logic signed [31:0] min_price;
  logic signed [31:0] max_price;
  logic [31:0]        now_time;
  modport source (output valid, operation, instrument, trade_price, trade_qty,
                  open_price, min_price, max_price, now_time, input ready);
  modport sink (input valid, operation, instrument, trade_price, trade_qty,
                open_price, min_price, max_price, now_time, output ready);
endinterface

interface tct_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_instrument;
  logic signed [31:0] out_last_price;
  logic signed [31:0] out_last_quantity;
  logic signed [31:0] out_open_price;
  logic signed [31:0] out_min_price;
  logic signed [31:0] out_max_price;
  logic               last_of_run;
  modport source (output valid, out_instrument, out_last_price, out_last_quantity,
                  out_open_price, out_min_price, out_max_price, last_of_run,
                  input ready);
  modport sink (input valid, out_instrument, out_last_price, out_last_quantity,
                out_open_price, out_min_price, out_max_price, last_of_run,
                output ready);
endinterface

interface tct_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] min_interval;
  modport source (output valid, min_interval, input ready);
  modport sink (input valid, min_interval, output ready);
endinterface

[hdl/tct_ram.sv]
`timescale 1ns / 1ps
module tct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ticker_conflation_throttle_top.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Handshake    | Carries
// cfg_i    | in  | valid/ready  | min_interval, always ready
// in_i     | in  | valid/ready  | operation, instrument, prices, now_time
// out_o    | out | valid/ready  | one published slot, last_of_run on the final one
//
// An update reads the slot word from the data memory when ST_IDLE accepts it,
// then merges it and writes it back in ST_UPD. A tick walks the queue: each
// entry costs a queue memory read (ST_TRD), a data memory read (ST_TQ) and an
// evaluate step (ST_TEV), plus the accepting step, the final length check and
// the flush of the held slot. Reset clears the slot flags, the queue length and
// the FSM; the memories hold no reset state. The walk stalls when a due slot is
// found while one slot is held and the output register still waits, and the
// flush waits until the output register is free.
module ticker_conflation_throttle_top import tct_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tct_cfg_if.sink   cfg_i,
  tct_in_if.sink    in_i,
  tct_out_if.source out_o
);

  localparam int unsigned IW = $clog2(SLOTS);

  state_e state_q, state_d;

  logic [IvalW-1:0] min_ival_q;

  // Per-slot status flags live in flip-flops so reset clears them at once.
  logic [SLOTS-1:0] present_q, present_d;
  logic [SLOTS-1:0] queued_q, queued_d;
  logic [SLOTS-1:0] fresh_q, fresh_d;
  logic [SLOTS-1:0] sent_q, sent_d;

  logic [IW:0] qlen_q, qlen_d;
  logic [IW:0] idx_q, idx_d;
  logic [IW:0] keep_q, keep_d;

  // Latched request.
  logic [IW-1:0]     inst_q, inst_d;
  logic [PriceW-1:0] lp_q, lp_d, lq_q, lq_d, op_q, op_d, mn_q, mn_d, mx_q, mx_d;
  logic [TimeW-1:0]  now_q, now_d;

  logic [IW-1:0] slot_q, slot_d;

  // A due slot is held back until the next due slot or the flush, so the last one of a run can be flagged.
  logic       held_v_q, held_v_d;
  logic [IW-1:0] held_slot_q, held_slot_d;
  slot_word_t held_q, held_d;

  logic       out_v_q, out_v_d;
  logic       out_last_q, out_last_d;
  logic [IW-1:0] out_slot_q, out_slot_d;
  slot_word_t out_q, out_d;

  // Memory ports.
  logic          dram_we, dram_re;
  logic [IW-1:0] dram_waddr, dram_raddr;
  slot_word_t    dram_wdata, dram_rdata;
  logic          qram_we, qram_re;
  logic [IW-1:0] qram_waddr, qram_raddr, qram_wdata, qram_rdata;

  tct_ram #(.Width(DataW), .Depth(SLOTS)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dram_we),
    .waddr_i(dram_waddr),
    .wdata_i(dram_wdata),
    .re_i   (dram_re),
    .raddr_i(dram_raddr),
    .rdata_o(dram_rdata)
  );

  tct_ram #(.Width(IW), .Depth(SLOTS)) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (qram_we),
    .waddr_i(qram_waddr),
    .wdata_i(qram_wdata),
    .re_i   (qram_re),
    .raddr_i(qram_raddr),
    .rdata_o(qram_rdata)
  );

  logic inst_ok;
  logic out_free;
  logic due;
  logic [TimeW-1:0] age;

  assign inst_ok  = ({26'd0, in_i.instrument} < 32'(SLOTS));
  assign out_free = !out_v_q || out_o.ready;
  assign age      = now_q - dram_rdata.sent_time;
  assign due      = !sent_q[slot_q] || (age > {{(TimeW-IvalW){1'b0}}, min_ival_q});

  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    queued_d    = queued_q;
    fresh_d     = fresh_q;
    sent_d      = sent_q;
    qlen_d      = qlen_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    inst_d      = inst_q;
    lp_d        = lp_q;
    lq_d        = lq_q;
    op_d        = op_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    now_d       = now_q;
    slot_d      = slot_q;
    held_v_d    = held_v_q;
    held_slot_d = held_slot_q;
    held_d      = held_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_last_d  = out_last_q;
    out_slot_d  = out_slot_q;
    out_d       = out_q;
    in_i.ready  = 1'b0;
    dram_we     = 1'b0;
    dram_re     = 1'b0;
    dram_waddr  = inst_q;
    dram_raddr  = IW'(in_i.instrument);
    dram_wdata  = dram_rdata;
    qram_we     = 1'b0;
    qram_re     = 1'b0;
    qram_waddr  = qlen_q[IW-1:0];
    qram_wdata  = inst_q;
    qram_raddr  = idx_q[IW-1:0];

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.operation == OP_TICK) begin
            now_d   = in_i.now_time;
            idx_d   = '0;
            keep_d  = '0;
            state_d = ST_TRD;
          end else if (inst_ok) begin
            inst_d  = IW'(in_i.instrument);
            lp_d    = in_i.trade_price;
            lq_d    = in_i.trade_qty;
            op_d    = in_i.open_price;
            mn_d    = in_i.min_price;
            mx_d    = in_i.max_price;
            dram_re = 1'b1;
            state_d = ST_UPD;
          end
        end
      end

      ST_UPD: begin
        // Merge into the word read last cycle and write it back.
        dram_we                = 1'b1;
        dram_wdata.trade_price = lp_q;
        dram_wdata.trade_qty   = lq_q;
        dram_wdata.open_price  = op_q;
        if (!present_q[inst_q] || fresh_q[inst_q]) begin
          dram_wdata.min_price = mn_q;
          dram_wdata.max_price = mx_q;
        end else begin
          if ($signed(mn_q) < $signed(dram_rdata.min_price)) begin
            dram_wdata.min_price = mn_q;
          end
          if ($signed(dram_rdata.max_price) < $signed(mx_q)) begin
            dram_wdata.max_price = mx_q;
          end
        end
        if (!present_q[inst_q]) begin
          present_d[inst_q] = 1'b1;
          fresh_d[inst_q]   = 1'b1;
          sent_d[inst_q]    = 1'b0;
        end else begin
          fresh_d[inst_q] = 1'b0;
        end
        if (!present_q[inst_q] || !queued_q[inst_q]) begin
          qram_we          = 1'b1;
          qlen_d           = qlen_q + 1'b1;
          queued_d[inst_q] = 1'b1;
        end
        state_d = ST_IDLE;
      end

      ST_TRD: begin
        if (idx_q == qlen_q) begin
          state_d = ST_FLUSH;
        end else begin
          qram_re = 1'b1;
          state_d = ST_TQ;
        end
      end

      ST_TQ: begin
        slot_d     = qram_rdata;
        dram_re    = 1'b1;
        dram_raddr = qram_rdata;
        idx_d      = idx_q + 1'b1;
        state_d    = ST_TEV;
      end

      ST_TEV: begin
        if (due) begin
          if (!held_v_q || out_free) begin
            if (held_v_q) begin
              out_v_d    = 1'b1;
              out_last_d = 1'b0;
              out_slot_d = held_slot_q;
              out_d      = held_q;
            end
            held_v_d    = 1'b1;
            held_slot_d = slot_q;
            held_d      = dram_rdata;
            dram_we              = 1'b1;
            dram_waddr           = slot_q;
            dram_wdata.sent_time = now_q;
            queued_d[slot_q] = 1'b0;
            sent_d[slot_q]   = 1'b1;
            state_d          = ST_TRD;
          end
        end else begin
          qram_we    = 1'b1;
          qram_waddr = keep_q[IW-1:0];
          qram_wdata = slot_q;
          keep_d     = keep_q + 1'b1;
          state_d    = ST_TRD;
        end
      end

      ST_FLUSH: begin
        if (!held_v_q) begin
          qlen_d  = keep_q;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_slot_d = held_slot_q;
          out_d      = held_q;
          held_v_d   = 1'b0;
          qlen_d     = keep_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ival_q <= '0;
      present_q  <= '0;
      queued_q   <= '0;
      fresh_q    <= '0;
      sent_q     <= '0;
      qlen_q     <= '0;
      idx_q      <= '0;
      keep_q     <= '0;
      held_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        min_ival_q <= cfg_i.min_interval;
      end
      present_q <= present_d;
      queued_q  <= queued_d;
      fresh_q   <= fresh_d;
      sent_q    <= sent_d;
      qlen_q    <= qlen_d;
      idx_q     <= idx_d;
      keep_q    <= keep_d;
      held_v_q  <= held_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inst_q      <= inst_d;
    lp_q        <= lp_d;
    lq_q        <= lq_d;
    op_q        <= op_d;
    mn_q        <= mn_d;
    mx_q        <= mx_d;
    now_q       <= now_d;
    slot_q      <= slot_d;
    held_slot_q <= held_slot_d;
    held_q      <= held_d;
    out_last_q  <= out_last_d;
    out_slot_q  <= out_slot_d;
    out_q       <= out_d;
  end

  assign out_o.valid             = out_v_q;
  assign out_o.out_instrument    = 6'(out_slot_q);
  assign out_o.out_last_price    = out_q.trade_price;
  assign out_o.out_last_quantity = out_q.trade_qty;
  assign out_o.out_open_price    = out_q.open_price;
  assign out_o.out_min_price     = out_q.min_price;
  assign out_o.out_max_price     = out_q.max_price;
  assign out_o.last_of_run       = out_last_q;

endmodule
